// ----- rtl/core/clg_pkg.sv -----
`default_nettype none
package clg_pkg;

  localparam int MAX_SIDE      = 64;
  localparam int COORD_W       = $clog2(MAX_SIDE);
  localparam int SIDE_W        = 7;
  localparam int GRID_DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int GRID_AW       = 2 * COORD_W;
  localparam int MAX_PARTICLES = 1024;
  localparam int PID_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int POS_W         = 2 * COORD_W;
  localparam int CODE_W        = 3;
  localparam int DISP_W        = 32;
  localparam int REQ_W         = 2;
  localparam int DIR_W         = 2;
  localparam int STEP_W        = 3;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [SIDE_W-1:0] SIDE_MIN   = 7'd7;
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd50;

  localparam logic [CFG_AW-3:0] REG_SIDE = 1'b0;

  localparam logic [CODE_W-1:0] CODE_EMPTY    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_P_CENTER = 3'd2;
  localparam logic [CODE_W-1:0] CODE_P_ARM    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_T_CENTER = 3'd5;
  localparam logic [CODE_W-1:0] CODE_T_ARM    = 3'd6;

  localparam logic [REQ_W-1:0] REQ_PLACE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [DIR_W-1:0] DIR_CPLUS  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RMINUS = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CMINUS = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RPLUS  = 2'd3;

  localparam logic [STEP_W-1:0] PROBE_LAST = 3'd5;
  localparam logic [STEP_W-1:0] PLACE_LAST = 3'd4;
  localparam logic [STEP_W-1:0] MOVE_LAST  = 3'd7;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } ofs_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] place_row;
    logic [COORD_W-1:0] place_col;
    logic [PID_W-1:0]   particle_id;
    logic [DIR_W-1:0]   direction;
  } item_t;

  typedef struct packed {
    logic                     accepted;
    logic [PID_W-1:0]         placed_index;
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [GRID_AW-1:0] addr;
    logic [CODE_W-1:0]  wdata;
  } grid_req_t;

  typedef struct packed {
    logic             we;
    logic [PID_W-1:0] addr;
    logic [POS_W-1:0] wdata;
  } pos_req_t;

  function automatic ofs_t fwd(input logic [DIR_W-1:0] dir);
    ofs_t f;
    f = '0;
    case (dir)
      DIR_CPLUS:  f.dc = 3'sd1;
      DIR_RMINUS: f.dr = -3'sd1;
      DIR_CMINUS: f.dc = -3'sd1;
      DIR_RPLUS:  f.dr = 3'sd1;
      default:    f = '0;
    endcase
    return f;
  endfunction

  // offsets from the base cell: place footprint, or the five cells ahead of a move
  function automatic ofs_t probe_ofs(input logic is_move, input logic [DIR_W-1:0] dir,
                                     input logic [STEP_W-1:0] k);
    ofs_t f;
    ofs_t o;
    logic signed [2:0] fr, fc, sr, sc;
    f  = fwd(dir);
    fr = f.dr;
    fc = f.dc;
    sr = fc;
    sc = fr;
    o  = '0;
    if (is_move) begin
      case (k)
        3'd0: begin o.dr = fr + fr + fr; o.dc = fc + fc + fc; end
        3'd1: begin o.dr = fr + fr + sr; o.dc = fc + fc + sc; end
        3'd2: begin o.dr = fr + fr - sr; o.dc = fc + fc - sc; end
        3'd3: begin o.dr = fr + sr + sr; o.dc = fc + sc + sc; end
        3'd4: begin o.dr = fr - sr - sr; o.dc = fc - sc - sc; end
        default: o = '0;
      endcase
    end else begin
      case (k)
        3'd1: o.dr = 3'sd1;
        3'd2: o.dr = -3'sd1;
        3'd3: o.dc = 3'sd1;
        3'd4: o.dc = -3'sd1;
        default: o = '0;
      endcase
    end
    return o;
  endfunction

  // move writes: new center, front arm, side arms, old center, then the cleared cells
  function automatic ofs_t write_ofs(input logic is_move, input logic [DIR_W-1:0] dir,
                                     input logic [STEP_W-1:0] k);
    ofs_t f;
    ofs_t o;
    logic signed [2:0] fr, fc, sr, sc;
    f  = fwd(dir);
    fr = f.dr;
    fc = f.dc;
    sr = fc;
    sc = fr;
    o  = '0;
    if (is_move) begin
      case (k)
        3'd0: begin o.dr = fr;      o.dc = fc;      end
        3'd1: begin o.dr = fr + fr; o.dc = fc + fc; end
        3'd2: begin o.dr = fr + sr; o.dc = fc + sc; end
        3'd3: begin o.dr = fr - sr; o.dc = fc - sc; end
        3'd4: o = '0;
        3'd5: begin o.dr = sr;      o.dc = sc;      end
        3'd6: begin o.dr = -sr;     o.dc = -sc;     end
        3'd7: begin o.dr = -fr;     o.dc = -fc;     end
        default: o = '0;
      endcase
    end else begin
      o = probe_ofs(1'b0, dir, k);
    end
    return o;
  endfunction

  function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] v,
                                                    input logic signed [2:0] d,
                                                    input logic [SIDE_W-1:0] side);
    logic signed [SIDE_W+1:0] s;
    logic signed [SIDE_W+1:0] l;
    l = $signed({2'b00, side});
    s = $signed({3'b000, v}) + (SIDE_W+2)'(d);
    if (s < 0) begin
      s = s + l;
    end else if (s >= l) begin
      s = s - l;
    end
    return s[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clg_ram.sv -----
`default_nettype none
module clg_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/clg_cfg.sv -----
`default_nettype none
module clg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [clg_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [clg_pkg::CFG_DW-1:0]     pwdata,
  output logic      [clg_pkg::CFG_DW-1:0]     prdata,
  output logic                                pready,
  output logic      [clg_pkg::SIDE_W-1:0]     side_use
);

  logic [clg_pkg::SIDE_W-1:0] side_r;
  logic [clg_pkg::SIDE_W-1:0] side_nxt;
  logic                       sel_side;

  assign pready   = 1'b1;
  assign sel_side = (paddr[clg_pkg::CFG_AW-1:2] == clg_pkg::REG_SIDE);

  always_comb begin
    side_nxt = side_r;
    if (psel && penable && pwrite && pready && sel_side) begin
      side_nxt = pwdata[clg_pkg::SIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= clg_pkg::SIDE_RESET;
    end else begin
      side_r <= side_nxt;
    end
  end

  assign prdata = sel_side ? clg_pkg::CFG_DW'(side_r) : '0;

  always_comb begin
    if (side_r < clg_pkg::SIDE_MIN) begin
      side_use = clg_pkg::SIDE_MIN;
    end else if (side_r > clg_pkg::SIDE_MAX) begin
      side_use = clg_pkg::SIDE_MAX;
    end else begin
      side_use = side_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/clg_seq.sv -----
`default_nettype none
module clg_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [clg_pkg::SIDE_W-1:0]  side,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire clg_pkg::item_t              in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output clg_pkg::result_t                 out_res,
  output clg_pkg::grid_req_t               grid_req,
  input  wire logic [clg_pkg::CODE_W-1:0]  grid_rdata,
  output clg_pkg::pos_req_t                pos_req,
  input  wire logic [clg_pkg::POS_W-1:0]   pos_rdata
);

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_POS   = 8'b0000_0100,
    S_RED   = 8'b0000_1000,
    S_CEN   = 8'b0001_0000,
    S_PROBE = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [clg_pkg::GRID_AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                               is_move_r, is_move_nxt;
  logic [clg_pkg::DIR_W-1:0]          dir_r, dir_nxt;
  logic [clg_pkg::PID_W-1:0]          id_r, id_nxt;
  logic [clg_pkg::COORD_W-1:0]        row_r, row_nxt;
  logic [clg_pkg::COORD_W-1:0]        col_r, col_nxt;
  logic [clg_pkg::CODE_W-1:0]         cen_r, cen_nxt;
  logic [clg_pkg::STEP_W-1:0]         k_r, k_nxt;
  logic                               blk_r, blk_nxt;
  logic                               ok_r, ok_nxt;
  logic [clg_pkg::PID_W-1:0]          idx_r, idx_nxt;
  logic [clg_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic signed [clg_pkg::DISP_W-1:0]  dx_r, dx_nxt;
  logic signed [clg_pkg::DISP_W-1:0]  dy_r, dy_nxt;
  logic                               out_valid_r, out_valid_nxt;
  clg_pkg::result_t                   out_r, out_nxt;

  clg_pkg::ofs_t                      ofs;
  clg_pkg::ofs_t                      f;
  logic [clg_pkg::COORD_W-1:0]        cell_row, cell_col;
  logic                               tracer;
  logic                               blocked;
  logic                               blk_acc;
  logic                               row_big, col_big;
  logic                               last_wr;
  logic [clg_pkg::CODE_W-1:0]         arm_code;
  logic [clg_pkg::CODE_W-1:0]         wr_code;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign f        = clg_pkg::fwd(dir_r);
  assign ofs      = (state_r == S_WRITE) ? clg_pkg::write_ofs(is_move_r, dir_r, k_r)
                                         : clg_pkg::probe_ofs(is_move_r, dir_r, k_r);
  assign cell_row = clg_pkg::wrap_coord(row_r, ofs.dr, side);
  assign cell_col = clg_pkg::wrap_coord(col_r, ofs.dc, side);
  assign tracer   = (cen_r == clg_pkg::CODE_T_CENTER);
  assign arm_code = tracer ? clg_pkg::CODE_T_ARM : clg_pkg::CODE_P_ARM;
  assign row_big  = ({1'b0, row_r} >= side);
  assign col_big  = ({1'b0, col_r} >= side);
  assign last_wr  = is_move_r ? (k_r == clg_pkg::MOVE_LAST) : (k_r == clg_pkg::PLACE_LAST);
  assign blk_acc  = blk_r | ((k_r != '0) && blocked);

  always_comb begin
    if (is_move_r) begin
      blocked = (grid_rdata == clg_pkg::CODE_P_CENTER) ||
                (!tracer && (grid_rdata == clg_pkg::CODE_T_CENTER));
    end else begin
      blocked = (grid_rdata != clg_pkg::CODE_EMPTY);
    end
  end

  always_comb begin
    if (k_r == '0) begin
      wr_code = cen_r;
    end else if (is_move_r && (k_r > 3'd4)) begin
      wr_code = clg_pkg::CODE_EMPTY;
    end else begin
      wr_code = arm_code;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    is_move_nxt   = is_move_r;
    dir_nxt       = dir_r;
    id_nxt        = id_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cen_nxt       = cen_r;
    k_nxt         = k_r;
    blk_nxt       = blk_r;
    ok_nxt        = ok_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    grid_req      = '0;
    pos_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        grid_req.we    = 1'b1;
        grid_req.addr  = clr_addr_r;
        grid_req.wdata = clg_pkg::CODE_EMPTY;
        clr_addr_nxt   = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        pos_req.addr = in_item.particle_id;
        if (in_valid) begin
          dir_nxt = in_item.direction;
          id_nxt  = in_item.particle_id;
          row_nxt = in_item.place_row;
          col_nxt = in_item.place_col;
          k_nxt   = '0;
          blk_nxt = 1'b0;
          ok_nxt  = 1'b0;
          idx_nxt = '0;
          case (in_item.req_type)
            clg_pkg::REQ_PLACE: begin
              is_move_nxt = 1'b0;
              cen_nxt     = (count_r == '0) ? clg_pkg::CODE_T_CENTER : clg_pkg::CODE_P_CENTER;
              state_nxt   = (count_r == clg_pkg::CNT_W'(clg_pkg::MAX_PARTICLES)) ? S_DONE
                                                                                  : S_RED;
            end
            clg_pkg::REQ_MOVE: begin
              is_move_nxt = 1'b1;
              state_nxt   = ({1'b0, in_item.particle_id} >= count_r) ? S_DONE : S_POS;
            end
            clg_pkg::REQ_CLEAR: begin
              dx_nxt    = '0;
              dy_nxt    = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_POS: begin
        row_nxt   = pos_rdata[clg_pkg::POS_W-1:clg_pkg::COORD_W];
        col_nxt   = pos_rdata[clg_pkg::COORD_W-1:0];
        state_nxt = S_RED;
      end
      S_RED: begin
        // iterative mod by the side, one subtract per cycle
        grid_req.addr = {row_r, col_r};
        if (row_big) begin
          row_nxt = clg_pkg::COORD_W'({1'b0, row_r} - side);
        end
        if (col_big) begin
          col_nxt = clg_pkg::COORD_W'({1'b0, col_r} - side);
        end
        if (!row_big && !col_big) begin
          k_nxt     = '0;
          blk_nxt   = 1'b0;
          state_nxt = is_move_r ? S_CEN : S_PROBE;
        end
      end
      S_CEN: begin
        cen_nxt = grid_rdata;
        if ((grid_rdata == clg_pkg::CODE_P_CENTER) || (grid_rdata == clg_pkg::CODE_T_CENTER)) begin
          state_nxt = S_PROBE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PROBE: begin
        // read issued for step k, data checked for step k-1
        grid_req.addr = {cell_row, cell_col};
        blk_nxt       = blk_acc;
        k_nxt         = k_r + 1'b1;
        if (k_r == clg_pkg::PROBE_LAST) begin
          k_nxt     = '0;
          state_nxt = blk_acc ? S_DONE : S_WRITE;
        end
      end
      S_WRITE: begin
        grid_req.we    = 1'b1;
        grid_req.addr  = {cell_row, cell_col};
        grid_req.wdata = wr_code;
        if (k_r == '0) begin
          pos_req.we    = 1'b1;
          pos_req.addr  = is_move_r ? id_r : count_r[clg_pkg::PID_W-1:0];
          pos_req.wdata = {cell_row, cell_col};
        end
        k_nxt = k_r + 1'b1;
        if (last_wr) begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
          if (!is_move_r) begin
            idx_nxt   = count_r[clg_pkg::PID_W-1:0];
            count_nxt = count_r + 1'b1;
          end else if (tracer) begin
            dx_nxt = dx_r + clg_pkg::DISP_W'(f.dc);
            dy_nxt = dy_r - clg_pkg::DISP_W'(f.dr);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.accepted     = ok_r;
          out_nxt.placed_index = idx_r;
          out_nxt.disp_x       = dx_r;
          out_nxt.disp_y       = dy_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_move_r <= is_move_nxt;
    dir_r     <= dir_nxt;
    id_r      <= id_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    cen_r     <= cen_nxt;
    k_r       <= k_nxt;
    blk_r     <= blk_nxt;
    ok_r      <= ok_nxt;
    idx_r     <= idx_nxt;
    out_r     <= out_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/cross_lattice_gas_move_step_unit.sv -----
`default_nettype none
// Plus-shaped hard-core lattice gas on a periodic grid, one request per item and one
// result item per request. After reset all 4096 grid cells are cleared before the first
// item is taken; configuration writes are taken meanwhile. All cell traffic goes through
// one single-port grid memory, so a request is served by a sequencer one cell access per
// cycle: clear, unused and rejected-early requests go straight to the result stage; a
// place reduces its coordinates, then probes and writes its footprint, and a move also
// reads its position first and checks its center cell before probing. The reduction
// takes n (0 to 9) side subtractions. The next item is accepted once the previous result
// is in the output register, while that result may still wait for out_tready.
module cross_lattice_gas_move_step_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // place_row[5:0], place_col[11:6], particle_id[21:12], direction[23:22]
  input  wire logic [23:0]                   in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // accepted[0], placed_index[10:1], disp_x[42:11], disp_y[74:43], zero[79:75]
  output logic [79:0]                        out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [clg_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [clg_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [clg_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [clg_pkg::SIDE_W-1:0] side_use;
  clg_pkg::item_t             item;
  clg_pkg::result_t           res;
  clg_pkg::grid_req_t         grid_req;
  clg_pkg::pos_req_t          pos_req;
  logic [clg_pkg::CODE_W-1:0] grid_rdata;
  logic [clg_pkg::POS_W-1:0]  pos_rdata;

  assign item.req_type    = in_tuser;
  assign item.place_row   = in_tdata[5:0];
  assign item.place_col   = in_tdata[11:6];
  assign item.particle_id = in_tdata[21:12];
  assign item.direction   = in_tdata[23:22];

  assign out_tdata = {5'b0, res.disp_y, res.disp_x, res.placed_index, res.accepted};

  clg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .side_use (side_use)
  );

  clg_ram #(
    .DEPTH (clg_pkg::GRID_DEPTH),
    .WIDTH (clg_pkg::CODE_W)
  ) u_grid (
    .clk   (clk),
    .we    (grid_req.we),
    .addr  (grid_req.addr),
    .wdata (grid_req.wdata),
    .rdata (grid_rdata)
  );

  clg_ram #(
    .DEPTH (clg_pkg::MAX_PARTICLES),
    .WIDTH (clg_pkg::POS_W)
  ) u_pos (
    .clk   (clk),
    .we    (pos_req.we),
    .addr  (pos_req.addr),
    .wdata (pos_req.wdata),
    .rdata (pos_rdata)
  );

  clg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .side       (side_use),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res),
    .grid_req   (grid_req),
    .grid_rdata (grid_rdata),
    .pos_req    (pos_req),
    .pos_rdata  (pos_rdata)
  );

`ifndef SYNTHESIS
  a_no_cell_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !grid_req.we)
    else $error("grid written while idle");

  a_pos_with_cell: assert property (@(posedge clk) disable iff (!rst_n)
    pos_req.we |-> grid_req.we)
    else $error("position written without a cell write");

  a_index_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.accepted) |-> (res.placed_index == '0))
    else $error("placed index set on a rejected item");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clg_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] SIDE_ADDR  = CFG_AW'(4 * int'(REG_SIDE));
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int PHASE_ITEMS    = 185;
  localparam int NUM_PHASES     = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata = '0;
  logic [1:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [79:0]         out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  cross_lattice_gas_move_step_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // lattice shadow state
  logic [CODE_W-1:0]        grid_code [GRID_DEPTH];
  logic [COORD_W-1:0]       ctr_row   [MAX_PARTICLES];
  logic [COORD_W-1:0]       ctr_col   [MAX_PARTICLES];
  int                       n_particles;
  logic signed [DISP_W-1:0] trc_dx;
  logic signed [DISP_W-1:0] trc_dy;
  logic [SIDE_W-1:0]        side_reg;

  item_t   pend_q[$];
  result_t want_q[$];
  item_t   cur_item;
  result_t want;

  int in_idle_pct  = 15;
  int out_idle_pct = 15;
  int n_errors     = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_place_ok   = 0;
  int n_move_ok    = 0;
  int n_sides      = 0;
  int quiet_cycles = 0;

  function automatic int side_in_use();
    if (side_reg < SIDE_MIN) return int'(SIDE_MIN);
    if (side_reg > SIDE_MAX) return int'(SIDE_MAX);
    return int'(side_reg);
  endfunction

  function automatic int wrap_c(int v, int d, int L);
    return (v + d + L) % L;
  endfunction

  function automatic int cell_idx(int r, int c, int dr, int dc, int L);
    return wrap_c(r, dr, L) * MAX_SIDE + wrap_c(c, dc, L);
  endfunction

  function automatic int fwd_row(logic [DIR_W-1:0] dir);
    case (dir)
      DIR_RMINUS: return -1;
      DIR_RPLUS:  return 1;
      default:    return 0;
    endcase
  endfunction

  function automatic int fwd_col(logic [DIR_W-1:0] dir);
    case (dir)
      DIR_CPLUS:  return 1;
      DIR_CMINUS: return -1;
      default:    return 0;
    endcase
  endfunction

  function automatic logic stops(logic [CODE_W-1:0] code, logic trc);
    if (code == CODE_P_CENTER) return 1'b1;
    return !trc && code == CODE_T_CENTER;
  endfunction

  task automatic lattice_step(input item_t it, output result_t res);
    int L, r, c, p, q, nr, nc, fr, fc, sr, sc;
    logic [CODE_W-1:0] cen, arm;
    logic trc, ok;
    logic [PID_W-1:0] idx;
    L   = side_in_use();
    ok  = 1'b0;
    idx = '0;
    case (it.req_type)
      REQ_PLACE: begin
        r = int'(it.place_row) % L;
        c = int'(it.place_col) % L;
        if (n_particles < MAX_PARTICLES &&
            grid_code[cell_idx(r, c, 0, 0, L)] == CODE_EMPTY &&
            grid_code[cell_idx(r, c, 1, 0, L)] == CODE_EMPTY &&
            grid_code[cell_idx(r, c, -1, 0, L)] == CODE_EMPTY &&
            grid_code[cell_idx(r, c, 0, 1, L)] == CODE_EMPTY &&
            grid_code[cell_idx(r, c, 0, -1, L)] == CODE_EMPTY) begin
          cen = (n_particles == 0) ? CODE_T_CENTER : CODE_P_CENTER;
          arm = (n_particles == 0) ? CODE_T_ARM : CODE_P_ARM;
          grid_code[cell_idx(r, c, 0, 0, L)]  = cen;
          grid_code[cell_idx(r, c, 1, 0, L)]  = arm;
          grid_code[cell_idx(r, c, -1, 0, L)] = arm;
          grid_code[cell_idx(r, c, 0, 1, L)]  = arm;
          grid_code[cell_idx(r, c, 0, -1, L)] = arm;
          ctr_row[n_particles] = COORD_W'(r);
          ctr_col[n_particles] = COORD_W'(c);
          idx = PID_W'(n_particles);
          n_particles++;
          ok = 1'b1;
          n_place_ok++;
        end
      end
      REQ_MOVE: begin
        if (int'(it.particle_id) < n_particles) begin
          p   = int'(ctr_row[it.particle_id]) % L;
          q   = int'(ctr_col[it.particle_id]) % L;
          cen = grid_code[p * MAX_SIDE + q];
          if (cen == CODE_P_CENTER || cen == CODE_T_CENTER) begin
            trc = (cen == CODE_T_CENTER);
            fr  = fwd_row(it.direction);
            fc  = fwd_col(it.direction);
            sr  = fc;
            sc  = fr;
            nr  = wrap_c(p, fr, L);
            nc  = wrap_c(q, fc, L);
            if (!(stops(grid_code[cell_idx(nr, nc, 2 * fr, 2 * fc, L)], trc) ||
                  stops(grid_code[cell_idx(nr, nc, fr + sr, fc + sc, L)], trc) ||
                  stops(grid_code[cell_idx(nr, nc, fr - sr, fc - sc, L)], trc) ||
                  stops(grid_code[cell_idx(nr, nc, 2 * sr, 2 * sc, L)], trc) ||
                  stops(grid_code[cell_idx(nr, nc, -2 * sr, -2 * sc, L)], trc))) begin
              arm = trc ? CODE_T_ARM : CODE_P_ARM;
              grid_code[cell_idx(nr, nc, 0, 0, L)]   = cen;
              grid_code[cell_idx(nr, nc, fr, fc, L)] = arm;
              grid_code[cell_idx(p, q, 0, 0, L)]     = arm;
              grid_code[cell_idx(nr, nc, sr, sc, L)] = arm;
              grid_code[cell_idx(nr, nc, -sr, -sc, L)] = arm;
              grid_code[cell_idx(p, q, sr, sc, L)]   = CODE_EMPTY;
              grid_code[cell_idx(p, q, -sr, -sc, L)] = CODE_EMPTY;
              grid_code[cell_idx(p, q, -fr, -fc, L)] = CODE_EMPTY;
              ctr_row[it.particle_id] = COORD_W'(nr);
              ctr_col[it.particle_id] = COORD_W'(nc);
              if (trc) begin
                trc_dx = trc_dx + DISP_W'(fc);
                trc_dy = trc_dy - DISP_W'(fr);
              end
              ok = 1'b1;
              n_move_ok++;
            end
          end
        end
      end
      REQ_CLEAR: begin
        trc_dx = '0;
        trc_dy = '0;
      end
      default: ;
    endcase
    res.accepted     = ok;
    res.placed_index = idx;
    res.disp_x       = trc_dx;
    res.disp_y       = trc_dy;
  endtask

  function automatic item_t mk_item(logic [REQ_W-1:0] req, int row, int col, int id, int dir);
    item_t it;
    it.req_type    = req;
    it.place_row   = COORD_W'(row);
    it.place_col   = COORD_W'(col);
    it.particle_id = PID_W'(id);
    it.direction   = DIR_W'(dir);
    return it;
  endfunction

  // mostly well-formed moves of live particles, with some places, clears and noise
  function automatic item_t rand_item(int id_span);
    item_t it;
    int roll;
    it.req_type    = REQ_MOVE;
    it.place_row   = COORD_W'($urandom);
    it.place_col   = COORD_W'($urandom);
    it.particle_id = PID_W'($urandom);
    it.direction   = DIR_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      it.req_type = REQ_PLACE;
    end else if (roll < 90) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 99) < 30) it.particle_id = '0;
        else it.particle_id = PID_W'($urandom_range(0, (id_span > 0) ? id_span - 1 : 0));
      end
    end else if (roll < 95) begin
      it.req_type = REQ_CLEAR;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic write_side(input int unsigned v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SIDE_ADDR;
    cfg_pwdata  <= CFG_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    side_reg = SIDE_W'(v);
    n_sides++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_tvalid || want_q.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        lattice_step(cur_item, want);
        want_q.push_back(want);
        n_items++;
      end
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          cur_item = pend_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_item.direction, cur_item.particle_id,
                        cur_item.place_col, cur_item.place_row};
          in_tuser  <= cur_item.req_type;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.accepted     = out_tdata[0];
        got.placed_index = out_tdata[10:1];
        got.disp_x       = out_tdata[42:11];
        got.disp_y       = out_tdata[74:43];
        n_results++;
        if (want_q.size() == 0) begin
          note_error("result item with nothing expected");
        end else begin
          exp_r = want_q.pop_front();
          if (got.accepted !== exp_r.accepted)
            note_error($sformatf("accepted expected %0d got %0d", exp_r.accepted,
                                 got.accepted));
          if (got.placed_index !== exp_r.placed_index)
            note_error($sformatf("placed_index expected %0d got %0d", exp_r.placed_index,
                                 got.placed_index));
          if (got.disp_x !== exp_r.disp_x)
            note_error($sformatf("disp_x expected %0d got %0d", exp_r.disp_x, got.disp_x));
          if (got.disp_y !== exp_r.disp_y)
            note_error($sformatf("disp_y expected %0d got %0d", exp_r.disp_y, got.disp_y));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int sides[NUM_PHASES];
    int span;
    foreach (grid_code[i]) grid_code[i] = CODE_EMPTY;
    n_particles = 0;
    trc_dx      = '0;
    trc_dy      = '0;
    side_reg    = SIDE_RESET;
    sides = '{50, 64, 0, 127, 13, 7, 33, 0};
    sides[NUM_PHASES-1] = $urandom_range(7, 64);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // smallest grid: wrap-around, modulo coordinates, unknown ids, all directions
    write_side(int'(SIDE_MIN));
    pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_PLACE, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_PLACE, 63, 63, 1023, 3));
    pend_q.push_back(mk_item(REQ_PLACE, 3, 3, 0, 0));
    pend_q.push_back(mk_item(REQ_PLACE, 0, 3, 0, 0));
    pend_q.push_back(mk_item(REQ_MOVE, 63, 63, 1023, 3));
    pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 3, 0));
    for (int d = 0; d < 4; d++) pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 0, d));
    for (int d = 0; d < 4; d++) pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 1, d));
    pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 2, 2));
    pend_q.push_back(mk_item(REQ_CLEAR, 0, 0, 0, 0));
    pend_q.push_back(mk_item(REQ_UNUSED, 63, 63, 1023, 3));
    pend_q.push_back(mk_item(REQ_PLACE, 6, 6, 0, 0));
    pend_q.push_back(mk_item(REQ_PLACE, 62, 1, 0, 0));
    pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 0, 1));
    pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 0, 3));
    pend_q.push_back(mk_item(REQ_MOVE, 0, 0, 2, 0));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_side(sides[ph]);
      in_idle_pct  = (ph == 2) ? 0 : 15;
      out_idle_pct = (ph == 2) ? 0 : 15;
      span = n_particles;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pend_q.push_back(rand_item(span));
        if (pend_q[$].req_type == REQ_PLACE) span++;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (want_q.size() != 0) note_error("expected results left over");
    $display("covered %0d items over %0d side settings, %0d results checked",
             n_items, n_sides, n_results);
    $display("%0d places and %0d moves carried out, %0d particles on the grid",
             n_place_ok, n_move_ok, n_particles);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/clg_pkg.sv
rtl/core/clg_ram.sv
rtl/core/clg_cfg.sv
rtl/core/clg_seq.sv
rtl/core/cross_lattice_gas_move_step_unit.sv
tb/sv/tb_top.sv
